// File: rtl/anlfe_pkg.sv
// shared types, codes and limits for the ack/nak length frame exchange
// no dependencies; imported by every module of the block
package anlfe_pkg;

	// limits on the response length and on the receive buffer
	localparam int MAX_FRAME_LEN = 4096;
	localparam int RECV_CAPACITY = 4096;
	localparam int LEN_W         = 16;
	localparam int CNT_W         = $clog2(RECV_CAPACITY + 1);
	localparam int TRIES_W       = 3;
	localparam logic [TRIES_W-1:0] TRY_LIMIT = 3'd4;

	// line control bytes
	localparam logic [7:0] BYTE_EOT = 8'h04;
	localparam logic [7:0] BYTE_ACK = 8'h06;
	localparam logic [7:0] BYTE_NAK = 8'h15;

	// reset values of the timer registers
	localparam logic [7:0] SHORT_TIMEOUT_RST = 8'd20;
	localparam logic [7:0] LONG_TIMEOUT_RST  = 8'd120;

	// configuration register indexes
	localparam logic [1:0] CFG_SESSION_MODE  = 2'd0;
	localparam logic [1:0] CFG_SHORT_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_LONG_TIMEOUT  = 2'd2;

	// session modes
	localparam logic [1:0] MODE_NORMAL       = 2'd0;
	localparam logic [1:0] MODE_CONNECT_ONLY = 2'd1;
	localparam logic [1:0] MODE_RESUME_END   = 2'd2;
	localparam logic [1:0] MODE_RESUME_EOT   = 2'd3;

	// item opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_EVENT = 2'd2;
	localparam logic [1:0] OP_POLL  = 2'd3;

	// line events
	localparam logic [2:0] EV_CONNECT     = 3'd0;
	localparam logic [2:0] EV_DISCONNECT  = 3'd1;
	localparam logic [2:0] EV_BUSY        = 3'd4;
	localparam logic [2:0] EV_TIMEOUT     = 3'd5;

	// control byte requests
	localparam logic [1:0] CTRL_NONE = 2'd0;
	localparam logic [1:0] CTRL_ACK  = 2'd1;
	localparam logic [1:0] CTRL_EOT  = 2'd2;

	// timer actions
	localparam logic [1:0] TACT_LEAVE = 2'd0;
	localparam logic [1:0] TACT_CLEAR = 2'd1;
	localparam logic [1:0] TACT_LOAD  = 2'd2;

	// session result codes
	localparam logic [2:0] RES_OK        = 3'd0;
	localparam logic [2:0] RES_INIT_FAIL = 3'd1;
	localparam logic [2:0] RES_NAK_OVER  = 3'd2;
	localparam logic [2:0] RES_LEN_ERR   = 3'd3;
	localparam logic [2:0] RES_CONN_DROP = 3'd4;
	localparam logic [2:0] RES_EOT_DROP  = 3'd5;

	// session phase, one-hot
	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_CONNECT = 8'b0000_0010,
		PH_RESUME  = 8'b0000_0100,
		PH_ACK     = 8'b0000_1000,
		PH_LENHI   = 8'b0001_0000,
		PH_LENLO   = 8'b0010_0000,
		PH_DATA    = 8'b0100_0000,
		PH_EOT     = 8'b1000_0000
	} phase_t;

	// live configuration
	typedef struct packed {
		logic [1:0] session_mode;
		logic [7:0] short_timeout;
		logic [7:0] long_timeout;
	} anlfe_cfg_t;

	// one result item
	typedef struct packed {
		logic        send_frame;
		logic        delay_before_send;
		logic [1:0]  send_control;
		logic [1:0]  timer_action;
		logic [7:0]  timer_value;
		logic        payload_valid;
		logic [11:0] payload_index;
		logic [7:0]  payload_data;
		logic        session_done;
		logic [2:0]  result_code;
	} anlfe_result_t;

endpackage

// File: rtl/ack_nak_length_frame_exchange.sv
// top level of the ack/nak length frame exchange: input register, core, result register
// depends on anlfe_pkg, anlfe_cfg and anlfe_core
//
// Requester side of an ack/nak modem-link exchange with a length-prefixed response. Each
// accepted item (a session start, a line byte, a line event or an idle poll) gives exactly
// one result item. The block takes one item per cycle while its results are taken; a result
// is offered once its item has passed the input register and then the result register,
// which loads behind the state machine and its combinational result logic. Backpressure
// on the result side stalls both registers, and an item is still taken while a result
// waits whenever the input register is empty.
// No clearing pass follows reset. Configuration is read live and should be written only
// while no item is in flight.
module ack_nak_length_frame_exchange (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // line_byte[7:0], event_code[10:8], zero[15:11]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // send_frame[0], delay_before_send[1], send_control[3:2],
	                              // timer_action[5:4], timer_value[13:6], payload_index[25:14],
	                              // payload_data[33:26], result_code[36:34], zero[39:37]
	output logic        m_tuser,  // payload_valid
	output logic        m_tlast,  // session_done
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import anlfe_pkg::*;

	anlfe_cfg_t    cfg;
	anlfe_result_t result_d;
	anlfe_result_t result_s2;

	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic [7:0] line_byte_s1;
	logic [2:0] event_code_s1;
	logic       valid_s2;
	logic       advance;

	// stage handshake
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1     <= s_tuser;
			line_byte_s1  <= s_tdata[7:0];
			event_code_s1 <= s_tdata[10:8];
		end
	end

	anlfe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	anlfe_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (advance),
		.opcode     (opcode_s1),
		.line_byte  (line_byte_s1),
		.event_code (event_code_s1),
		.cfg        (cfg),
		.result     (result_d)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	// result packing
	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.payload_valid;
	assign m_tlast  = result_s2.session_done;
	assign m_tdata  = {3'b000,
	                   result_s2.result_code,
	                   result_s2.payload_data,
	                   result_s2.payload_index,
	                   result_s2.timer_value,
	                   result_s2.timer_action,
	                   result_s2.send_control,
	                   result_s2.delay_before_send,
	                   result_s2.send_frame};

endmodule

// File: rtl/anlfe_cfg.sv
// configuration registers: session mode and the two timer values
// depends on anlfe_pkg
module anlfe_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	output anlfe_pkg::anlfe_cfg_t cfg
);
	import anlfe_pkg::*;

	logic [1:0] session_mode_q;
	logic [7:0] short_timeout_q;
	logic [7:0] long_timeout_q;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_mode_q  <= MODE_NORMAL;
			short_timeout_q <= SHORT_TIMEOUT_RST;
			long_timeout_q  <= LONG_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SESSION_MODE:  session_mode_q  <= cfg_data[1:0];
				CFG_SHORT_TIMEOUT: short_timeout_q <= cfg_data;
				CFG_LONG_TIMEOUT:  long_timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.session_mode  = session_mode_q;
	assign cfg.short_timeout = short_timeout_q;
	assign cfg.long_timeout  = long_timeout_q;

endmodule

// File: rtl/anlfe_core.sv
// session state machine: holds phase, tries and counts, and forms one result per item
// depends on anlfe_pkg
module anlfe_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  logic [1:0]               opcode,
	input  logic [7:0]               line_byte,
	input  logic [2:0]               event_code,
	input  anlfe_pkg::anlfe_cfg_t    cfg,
	output anlfe_pkg::anlfe_result_t result
);
	import anlfe_pkg::*;

	phase_t             phase_q, phase_d;
	logic [TRIES_W-1:0] send_tries_q, send_tries_d;
	logic [LEN_W-1:0]   exp_len_q, exp_len_d;
	logic [CNT_W-1:0]   recv_cnt_q, recv_cnt_d;

	logic             fin;
	logic [2:0]       fin_code;
	logic             drop;
	logic [LEN_W-1:0] len_sum;
	logic [CNT_W-1:0] cnt_inc;

	assign drop    = event_code inside {[EV_DISCONNECT:EV_TIMEOUT]};
	assign len_sum = exp_len_q + LEN_W'(line_byte);
	assign cnt_inc = recv_cnt_q + CNT_W'(1);

	// next state and result for the item in the input register
	always_comb begin
		result       = '0;
		phase_d      = phase_q;
		send_tries_d = send_tries_q;
		exp_len_d    = exp_len_q;
		recv_cnt_d   = recv_cnt_q;
		fin          = 1'b0;
		fin_code     = RES_OK;
		case (opcode)
			OP_START: begin
				send_tries_d = '0;
				exp_len_d    = '0;
				recv_cnt_d   = '0;
				if (cfg.session_mode == MODE_RESUME_END || cfg.session_mode == MODE_RESUME_EOT) begin
					phase_d = PH_RESUME;
				end else begin
					phase_d = PH_CONNECT;
					if (cfg.session_mode == MODE_NORMAL) begin
						result.timer_action = TACT_LOAD;
						result.timer_value  = cfg.short_timeout;
					end
				end
			end
			OP_BYTE: begin
				case (phase_q)
					PH_ACK: begin
						if (line_byte == BYTE_ACK) begin
							result.timer_action = TACT_LOAD;
							result.timer_value  = cfg.long_timeout;
							phase_d             = PH_LENHI;
						end else if (line_byte == BYTE_NAK) begin
							if (send_tries_q < TRY_LIMIT) begin
								result.delay_before_send = 1'b1;
								result.timer_action      = TACT_LOAD;
								result.timer_value       = cfg.short_timeout;
								result.send_frame        = 1'b1;
								send_tries_d             = send_tries_q + TRIES_W'(1);
							end else begin
								fin      = 1'b1;
								fin_code = RES_NAK_OVER;
							end
						end
					end
					PH_LENHI: begin
						exp_len_d = {line_byte, 8'h00};
						phase_d   = PH_LENLO;
					end
					PH_LENLO: begin
						phase_d = PH_DATA;
						if (len_sum >= LEN_W'(MAX_FRAME_LEN)) begin
							exp_len_d           = '0;
							result.send_control = CTRL_EOT;
							fin                 = 1'b1;
							fin_code            = RES_LEN_ERR;
						end else begin
							exp_len_d = len_sum;
						end
					end
					PH_DATA: begin
						if (recv_cnt_q >= CNT_W'(RECV_CAPACITY)) begin
							// receive overflow, byte dropped
							exp_len_d = '0;
							fin       = 1'b1;
							fin_code  = RES_LEN_ERR;
						end else begin
							result.payload_valid = 1'b1;
							result.payload_index = 12'(recv_cnt_q);
							result.payload_data  = line_byte;
							recv_cnt_d           = cnt_inc;
							if (LEN_W'(cnt_inc) == exp_len_q) begin
								result.send_control = CTRL_ACK;
								if (cfg.session_mode == MODE_RESUME_END) begin
									fin      = 1'b1;
									fin_code = RES_OK;
								end else begin
									result.timer_action = TACT_LOAD;
									result.timer_value  = cfg.short_timeout;
									phase_d             = PH_EOT;
								end
							end
						end
					end
					PH_EOT: begin
						if (line_byte == BYTE_EOT) begin
							result.send_control = CTRL_EOT;
							fin                 = 1'b1;
							fin_code            = RES_OK;
						end
					end
					default: ;
				endcase
			end
			OP_EVENT: begin
				case (phase_q)
					PH_CONNECT: begin
						if (event_code == EV_CONNECT) begin
							if (cfg.session_mode == MODE_CONNECT_ONLY) begin
								fin      = 1'b1;
								fin_code = RES_OK;
							end else begin
								result.timer_action = TACT_LOAD;
								result.timer_value  = cfg.short_timeout;
								result.send_frame   = 1'b1;
								send_tries_d        = send_tries_q + TRIES_W'(1);
								phase_d             = PH_ACK;
							end
						end else if (drop) begin
							fin      = 1'b1;
							fin_code = RES_INIT_FAIL;
						end
					end
					PH_ACK: begin
						if (drop) begin
							fin      = 1'b1;
							fin_code = RES_CONN_DROP;
						end
					end
					PH_LENHI, PH_LENLO, PH_DATA: begin
						if (drop) begin
							recv_cnt_d = '0;
							fin        = 1'b1;
							fin_code   = RES_LEN_ERR;
						end
					end
					PH_EOT: begin
						// line timeout while awaiting eot still counts as success
						if (event_code inside {[EV_DISCONNECT:EV_BUSY]}) begin
							fin      = 1'b1;
							fin_code = RES_EOT_DROP;
						end else if (event_code == EV_TIMEOUT) begin
							fin      = 1'b1;
							fin_code = RES_OK;
						end
					end
					default: ;
				endcase
			end
			OP_POLL: begin
				if (phase_q == PH_RESUME) begin
					result.timer_action = TACT_LOAD;
					result.timer_value  = cfg.long_timeout;
					result.send_frame   = 1'b1;
					send_tries_d        = send_tries_q + TRIES_W'(1);
					phase_d             = PH_ACK;
				end
			end
			default: ;
		endcase
		// session end
		if (fin) begin
			result.timer_action = TACT_CLEAR;
			result.timer_value  = '0;
			result.session_done = 1'b1;
			result.result_code  = fin_code;
			phase_d             = PH_IDLE;
		end
	end

	// state update once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			send_tries_q <= '0;
			exp_len_q    <= '0;
			recv_cnt_q   <= '0;
		end else if (item_valid) begin
			phase_q      <= phase_d;
			send_tries_q <= send_tries_d;
			exp_len_q    <= exp_len_d;
			recv_cnt_q   <= recv_cnt_d;
		end
	end

endmodule

// File: rtl/anlfe_checker.sv
// port-level checks for the ack/nak length frame exchange, bound to the top level
// depends on anlfe_pkg and ack_nak_length_frame_exchange
module anlfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);
	import anlfe_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// an empty result register always lets an item in
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with result register empty");

	// session end always clears the timer
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[5:4] == TACT_CLEAR)
		else $error("session end without timer clear");

	// no result code unless the session ends
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[36:34] == RES_OK)
		else $error("result code outside session end");

	// a resend pause only comes with a frame send
	a_delay: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("resend pause without frame send");

endmodule

bind ack_nak_length_frame_exchange anlfe_checker u_anlfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
